// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, register map, code values and helpers for the polyline
// segment decimator.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS_DEF = 28;
  localparam int SQ_BITS        = 59;
  localparam int DIST_BITS      = 29;
  localparam int SPACING_BITS   = 48;
  localparam int LIMIT_BITS     = 8;
  localparam int KIND_BITS      = 8;
  localparam int IDENT_BITS     = 16;
  localparam int CLASS_BITS     = 2;
  localparam int ADDR_BITS      = 6;
  localparam int DATA_BITS      = 64;

  localparam logic [SQ_BITS-1:0]      SQ_MAX   = '1;
  localparam logic [DIST_BITS-1:0]    DIST_MAX = '1;
  localparam logic [SQ_BITS-1:0]      ROOT_TOP = {1'b1, (SQ_BITS-1)'(0)};

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 48'd1573519;
  localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET   = 8'd10;

  localparam logic [2:0] REG_SPACING = 3'd0;
  localparam logic [2:0] REG_EGO_X   = 3'd1;
  localparam logic [2:0] REG_EGO_Y   = 3'd2;
  localparam logic [2:0] REG_LIMIT   = 3'd3;
  localparam logic [2:0] REG_MODE    = 3'd4;

  localparam logic [KIND_BITS-1:0] KIND_DASHED = 8'd1;
  localparam logic [KIND_BITS-1:0] KIND_EDGE   = 8'd5;

  localparam logic [CLASS_BITS-1:0] CLASS_DASHED   = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_SOLID    = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_EDGE     = 2'd2;
  localparam logic [CLASS_BITS-1:0] CLASS_PROPOSAL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF_P,
    S_MUL_PX,
    S_MUL_PY,
    S_CHECK,
    S_MUL_EX,
    S_MUL_EY,
    S_UPDATE,
    S_ROOT,
    S_EMIT
  } state_t;

  function automatic logic [CLASS_BITS-1:0] kind_class(input logic [KIND_BITS-1:0] kind);
    logic [CLASS_BITS-1:0] c;
    priority if (kind == KIND_DASHED) begin
      c = CLASS_DASHED;
    end else if (kind == KIND_EDGE) begin
      c = CLASS_EDGE;
    end else begin
      c = CLASS_SOLID;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/polyline_segment_decimator.sv
// ----------------------------------------------------------------------------
// polyline_segment_decimator
// Thins the points of a line by spacing and emits grouped segment nodes.
// ----------------------------------------------------------------------------
// Points are taken one at a time and handled by a small sequencer around one
// shared subtract-and-square unit: dropped points end at the spacing check,
// a line's first point after its ego distance, a kept point once its node
// is emitted, and a point that closes its group runs the bit-per-cycle
// square root of the group's least ego distance first. The squarings of a
// point (two if it is dropped, four otherwise) go through the one multiplier
// in turn. A finished node sits in the output register while the next point
// is taken; the block stalls only if a second node is ready before the first
// is taken. Registers are at byte address 8*i, 64-bit data.
module polyline_segment_decimator #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [psd_pkg::ADDR_BITS-1:0]         paddr,
  input  logic [psd_pkg::DATA_BITS-1:0]         pwdata,
  output logic [psd_pkg::DATA_BITS-1:0]         prdata,
  output logic                                  pready,
  input  logic                                  point_valid,
  output logic                                  point_ready,
  input  logic signed [COORD_BITS-1:0]          point_x,
  input  logic signed [COORD_BITS-1:0]          point_y,
  input  logic                                  end_of_line,
  input  logic [psd_pkg::KIND_BITS-1:0]         line_kind,
  input  logic [psd_pkg::IDENT_BITS-1:0]        line_ident,
  output logic                                  node_valid,
  input  logic                                  node_ready,
  output logic signed [COORD_BITS-1:0]          start_x,
  output logic signed [COORD_BITS-1:0]          start_y,
  output logic signed [COORD_BITS-1:0]          end_x,
  output logic signed [COORD_BITS-1:0]          end_y,
  output logic [psd_pkg::CLASS_BITS-1:0]        line_class,
  output logic [psd_pkg::IDENT_BITS-1:0]        node_ident,
  output logic                                  group_last,
  output logic [psd_pkg::DIST_BITS-1:0]         group_min_dist
);

  localparam int MAG_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int SUM_BITS  = (PROD_BITS + 1 > psd_pkg::SQ_BITS + 1) ?
                             PROD_BITS + 1 : psd_pkg::SQ_BITS + 1;
  localparam int SQ_BITS   = psd_pkg::SQ_BITS;

  psd_pkg::state_t state, state_next;

  logic [psd_pkg::SPACING_BITS-1:0] spacing_sq;
  logic signed [COORD_BITS-1:0]     ego_x;
  logic signed [COORD_BITS-1:0]     ego_y;
  logic [psd_pkg::LIMIT_BITS-1:0]   group_limit;
  logic                             mode;

  logic signed [COORD_BITS-1:0]     pt_x;
  logic signed [COORD_BITS-1:0]     pt_y;
  logic                             pt_eol;
  logic [psd_pkg::KIND_BITS-1:0]    pt_kind;
  logic [psd_pkg::IDENT_BITS-1:0]   pt_ident;

  logic signed [COORD_BITS-1:0]     prev_x;
  logic signed [COORD_BITS-1:0]     prev_y;
  logic                             awaiting_start;
  logic [psd_pkg::LIMIT_BITS-1:0]   nodes_in_group;
  logic [SQ_BITS-1:0]               group_min_sq;

  logic [MAG_BITS-1:0]              mag;
  logic [PROD_BITS-1:0]             sq_a;
  logic [PROD_BITS-1:0]             sq_b;
  logic                             close_flag;
  logic [SQ_BITS-1:0]               root_rem;
  logic [SQ_BITS-1:0]               root_res;
  logic [SQ_BITS-1:0]               root_bit;

  logic [COORD_BITS-1:0]            op_a;
  logic [COORD_BITS-1:0]            op_b;
  logic [MAG_BITS-1:0]              diff;
  logic [MAG_BITS-1:0]              mag_next;
  logic [PROD_BITS-1:0]             prod;
  logic [SUM_BITS-1:0]              sum;
  logic [SQ_BITS-1:0]               sq_sat;
  logic [SQ_BITS-1:0]               min_next;
  logic [psd_pkg::LIMIT_BITS-1:0]   count_next;
  logic                             close_next;
  logic                             skip;
  logic [SQ_BITS:0]                 trial;
  logic                             take;
  logic                             root_done;
  logic [psd_pkg::DIST_BITS-1:0]    dist_sat;
  logic                             load_out;
  logic                             cfg_wr;

  // shared subtract and square unit
  always_comb begin
    unique case (state)
      psd_pkg::S_DIFF_P: begin
        op_a = pt_x;
        op_b = prev_x;
      end
      psd_pkg::S_MUL_PX: begin
        op_a = pt_y;
        op_b = prev_y;
      end
      psd_pkg::S_CHECK: begin
        op_a = pt_x;
        op_b = ego_x;
      end
      psd_pkg::S_MUL_EX: begin
        op_a = pt_y;
        op_b = ego_y;
      end
      default: begin
        op_a = pt_x;
        op_b = prev_x;
      end
    endcase
  end

  assign diff     = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
  assign mag_next = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : diff;
  assign prod     = PROD_BITS'(mag) * PROD_BITS'(mag);
  assign sum      = SUM_BITS'(sq_a) + SUM_BITS'(sq_b);
  assign sq_sat   = (sum > SUM_BITS'(psd_pkg::SQ_MAX)) ? psd_pkg::SQ_MAX
                                                        : sum[SQ_BITS-1:0];

  assign skip       = !awaiting_start && !pt_eol && (sq_sat <= SQ_BITS'(spacing_sq));
  assign min_next   = (sq_sat < group_min_sq) ? sq_sat : group_min_sq;
  assign count_next = (nodes_in_group != '1) ? nodes_in_group + 1'b1 : nodes_in_group;
  assign close_next = pt_eol || ((group_limit != '0) && (count_next >= group_limit));

  // one result bit per cycle
  assign trial     = (SQ_BITS + 1)'(root_res) + (SQ_BITS + 1)'(root_bit);
  assign take      = {1'b0, root_rem} >= trial;
  assign root_done = root_bit[0];
  assign dist_sat  = (root_res > SQ_BITS'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                              : root_res[psd_pkg::DIST_BITS-1:0];

  assign load_out = (state == psd_pkg::S_EMIT) && (!node_valid || node_ready);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    point_ready = 1'b0;
    unique case (state)
      psd_pkg::S_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          state_next = psd_pkg::S_DIFF_P;
        end
      end
      psd_pkg::S_DIFF_P: state_next = psd_pkg::S_MUL_PX;
      psd_pkg::S_MUL_PX: state_next = psd_pkg::S_MUL_PY;
      psd_pkg::S_MUL_PY: state_next = psd_pkg::S_CHECK;
      psd_pkg::S_CHECK: begin
        state_next = skip ? psd_pkg::S_IDLE : psd_pkg::S_MUL_EX;
      end
      psd_pkg::S_MUL_EX: state_next = psd_pkg::S_MUL_EY;
      psd_pkg::S_MUL_EY: state_next = psd_pkg::S_UPDATE;
      psd_pkg::S_UPDATE: begin
        if (awaiting_start) begin
          state_next = psd_pkg::S_IDLE;
        end else if (close_next) begin
          state_next = psd_pkg::S_ROOT;
        end else begin
          state_next = psd_pkg::S_EMIT;
        end
      end
      psd_pkg::S_ROOT: begin
        if (root_done) begin
          state_next = psd_pkg::S_EMIT;
        end
      end
      psd_pkg::S_EMIT: begin
        if (load_out) begin
          state_next = psd_pkg::S_IDLE;
        end
      end
      default: state_next = psd_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == psd_pkg::S_IDLE && point_valid) begin
      pt_x     <= point_x;
      pt_y     <= point_y;
      pt_eol   <= end_of_line;
      pt_kind  <= line_kind;
      pt_ident <= line_ident;
    end
    if (state == psd_pkg::S_DIFF_P || state == psd_pkg::S_MUL_PX ||
        state == psd_pkg::S_CHECK  || state == psd_pkg::S_MUL_EX) begin
      mag <= mag_next;
    end
    if (state == psd_pkg::S_MUL_PX || state == psd_pkg::S_MUL_EX) begin
      sq_a <= prod;
    end
    if (state == psd_pkg::S_MUL_PY || state == psd_pkg::S_MUL_EY) begin
      sq_b <= prod;
    end
    if (state == psd_pkg::S_UPDATE) begin
      close_flag <= close_next;
      root_rem   <= min_next;
      root_res   <= '0;
      root_bit   <= psd_pkg::ROOT_TOP;
    end
    if (state == psd_pkg::S_ROOT) begin
      if (take) begin
        root_rem <= root_rem - trial[SQ_BITS-1:0];
        root_res <= (root_res >> 1) + root_bit;
      end else begin
        root_res <= root_res >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (load_out) begin
      start_x        <= prev_x;
      start_y        <= prev_y;
      end_x          <= pt_x;
      end_y          <= pt_y;
      line_class     <= mode ? psd_pkg::CLASS_PROPOSAL : psd_pkg::kind_class(pt_kind);
      node_ident     <= mode ? pt_ident : '0;
      group_last     <= close_flag;
      group_min_dist <= close_flag ? dist_sat : '0;
    end
  end

  // line and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_valid     <= 1'b0;
      prev_x         <= '0;
      prev_y         <= '0;
      awaiting_start <= 1'b1;
      nodes_in_group <= '0;
      group_min_sq   <= psd_pkg::SQ_MAX;
    end else begin
      if (load_out) begin
        node_valid <= 1'b1;
      end else if (node_ready) begin
        node_valid <= 1'b0;
      end
      if (state == psd_pkg::S_UPDATE) begin
        if (awaiting_start) begin
          prev_x <= pt_x;
          prev_y <= pt_y;
          if (pt_eol) begin
            nodes_in_group <= '0;
            group_min_sq   <= psd_pkg::SQ_MAX;
          end else begin
            awaiting_start <= 1'b0;
            group_min_sq   <= min_next;
          end
        end else begin
          nodes_in_group <= count_next;
          group_min_sq   <= min_next;
        end
      end
      if (load_out) begin
        prev_x <= pt_x;
        prev_y <= pt_y;
        if (close_flag) begin
          nodes_in_group <= '0;
          group_min_sq   <= psd_pkg::SQ_MAX;
        end
        if (pt_eol) begin
          awaiting_start <= 1'b1;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_sq  <= psd_pkg::SPACING_RESET;
      ego_x       <= '0;
      ego_y       <= '0;
      group_limit <= psd_pkg::LIMIT_RESET;
      mode        <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[psd_pkg::ADDR_BITS-1:3])
        psd_pkg::REG_SPACING: spacing_sq  <= pwdata[psd_pkg::SPACING_BITS-1:0];
        psd_pkg::REG_EGO_X:   ego_x       <= pwdata[COORD_BITS-1:0];
        psd_pkg::REG_EGO_Y:   ego_y       <= pwdata[COORD_BITS-1:0];
        psd_pkg::REG_LIMIT:   group_limit <= pwdata[psd_pkg::LIMIT_BITS-1:0];
        psd_pkg::REG_MODE:    mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[psd_pkg::ADDR_BITS-1:3])
      psd_pkg::REG_SPACING: prdata = psd_pkg::DATA_BITS'(spacing_sq);
      psd_pkg::REG_EGO_X:   prdata = psd_pkg::DATA_BITS'(unsigned'(ego_x));
      psd_pkg::REG_EGO_Y:   prdata = psd_pkg::DATA_BITS'(unsigned'(ego_y));
      psd_pkg::REG_LIMIT:   prdata = psd_pkg::DATA_BITS'(group_limit);
      psd_pkg::REG_MODE:    prdata = psd_pkg::DATA_BITS'(mode);
      default:              prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the polyline segment decimator, bound to the top.
// ----------------------------------------------------------------------------
module psd_checker #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  point_valid,
  input logic                                  point_ready,
  input logic                                  node_valid,
  input logic                                  node_ready,
  input logic signed [COORD_BITS-1:0]          start_x,
  input logic signed [COORD_BITS-1:0]          start_y,
  input logic signed [COORD_BITS-1:0]          end_x,
  input logic signed [COORD_BITS-1:0]          end_y,
  input logic                                  group_last,
  input logic [psd_pkg::DIST_BITS-1:0]         group_min_dist
);

  // idle and empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> point_ready && !node_valid)
    else $error("not idle after reset");

  // an accepted item keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> !point_ready)
    else $error("ready right after accepting an item");

  // a stalled node holds
  a_node_hold: assert property (@(posedge clk) disable iff (rst)
    node_valid && !node_ready |=> node_valid && $stable(end_x) && $stable(end_y)
      && $stable(start_x) && $stable(start_y) && $stable(group_last))
    else $error("stalled node changed");

  // distance only on group closing nodes
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    node_valid && !group_last |-> group_min_dist == '0)
    else $error("distance on a node that does not close its group");

endmodule

bind polyline_segment_decimator psd_checker #(.COORD_BITS(COORD_BITS)) u_psd_checker (.*);
